@@ rtl/core/skrt_pkg.sv @@
// ----------------------------------------------------------------------------
// skrt_pkg
// Shared types and codes for the sorted keyed record table: operation and
// status codes, sequencer states and the records passed between modules.
// ----------------------------------------------------------------------------
package skrt_pkg;

   localparam int unsigned DATA_W = 32;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_LOOKUP = 3'd1,
      OP_UPDATE = 3'd2,
      OP_ERASE  = 3'd3,
      OP_DUMP   = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_NOT_FOUND = 3'd1,
      STAT_DUPLICATE = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DECIDE,
      S_INS_RD,
      S_INS_WR,
      S_DEL_RD,
      S_DEL_WR,
      S_DUMP_RD,
      S_DUMP_EMIT,
      S_RESPOND
   } state_type;

   // Result of the shared arithmetic unit.
   typedef struct packed {
      logic                     lt;
      logic                     eq;
      logic signed [DATA_W-1:0] sum;
   } alu_out_type;

   // Write request into the record store.
   typedef struct packed {
      logic                     en;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] qty;
   } wr_type;

endpackage

@@ rtl/core/skrt_alu.sv @@
// ----------------------------------------------------------------------------
// skrt_alu
// Shared arithmetic unit: signed compare and equality on keys, and the
// wrapping add used to update a quantity.
// ----------------------------------------------------------------------------
module skrt_alu (
   input  logic signed [skrt_pkg::DATA_W-1:0] op_a,
   input  logic signed [skrt_pkg::DATA_W-1:0] op_b,
   output skrt_pkg::alu_out_type              result
);

   always_comb begin
      result.lt  = (op_a < op_b);
      result.eq  = (op_a == op_b);
      result.sum = op_a + op_b;
   end

endmodule

@@ rtl/core/skrt_store.sv @@
// ----------------------------------------------------------------------------
// skrt_store
// Record memory: one write port and one read port with registered read data,
// keys and quantities side by side.
// ----------------------------------------------------------------------------
module skrt_store #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                               clock,
   input  logic [$clog2(DEPTH)-1:0]           wr_addr,
   input  skrt_pkg::wr_type                   wr,
   input  logic [$clog2(DEPTH)-1:0]           rd_addr,
   output logic signed [skrt_pkg::DATA_W-1:0] rd_key,
   output logic signed [skrt_pkg::DATA_W-1:0] rd_qty
);

   logic signed [skrt_pkg::DATA_W-1:0] key_mem [DEPTH];
   logic signed [skrt_pkg::DATA_W-1:0] qty_mem [DEPTH];
   logic signed [skrt_pkg::DATA_W-1:0] rd_key_ff;
   logic signed [skrt_pkg::DATA_W-1:0] rd_qty_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr_addr] <= wr.key;
         qty_mem[wr_addr] <= wr.qty;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_addr];
      rd_qty_ff <= qty_mem[rd_addr];
   end

   assign rd_key = rd_key_ff;
   assign rd_qty = rd_qty_ff;

endmodule

@@ rtl/core/sorted_keyed_record_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_keyed_record_table_core
// Bounded table of signed key / signed quantity records kept in ascending
// key order, with insert, lookup, update, erase and ordered dump.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, req_opcode, req_part_key,
// req_amount) takes one item at a time; req_stall stays high while an item
// is being worked on. The response channel (rsp_valid, rsp_stall, rsp_*)
// returns one item per insert, lookup, update or erase, and one item per
// stored record for a dump (one empty-status item if the table is empty);
// rsp_last marks the final response item of a request. Unused opcodes are
// consumed silently.
// The sequencer walks the table through a memory with a registered read
// port, reading and then comparing each record visited. Locating a key
// scans from the first record up to its position; an insert or erase then
// moves each record from that point on by one slot, and a dump reads and
// emits the stored records in order.
// Reset clears the record count and the sequencer; the memory itself is not
// cleared since only slots below the count are ever used. While the receiver
// stalls, the finished response item is held in the output register and the
// sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
module sorted_keyed_record_table_core #(
   parameter int unsigned MAX_ENTRIES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_part_key,
   input  logic signed [31:0] req_amount,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_out_key,
   output logic signed [31:0] rsp_out_quantity,
   output logic               rsp_last
);

   localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);

   // Sequencer state and the item under work.
   skrt_pkg::state_type state_ff, state_in;
   logic [2:0]          op_ff, op_in;
   logic signed [31:0]  key_ff, key_in;
   logic signed [31:0]  amt_ff, amt_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                found_ff, found_in;
   logic [2:0]          status_ff, status_in;
   logic signed [31:0]  qty_ff, qty_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic signed [31:0]  rsp_key_ff, rsp_key_in;
   logic signed [31:0]  rsp_qty_ff, rsp_qty_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_accept;
   logic                out_free;
   logic                rsp_load;
   logic [CNT_W-1:0]    idx_inc;
   logic [CNT_W-1:0]    idx_dec;
   logic                dump_last;

   // Memory and shared unit connections.
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic [CNT_W-1:0]    rd_idx;
   logic [CNT_W-1:0]    wr_idx;
   skrt_pkg::wr_type    wr;
   logic signed [31:0]  rd_key;
   logic signed [31:0]  rd_qty;
   logic signed [31:0]  alu_a;
   logic signed [31:0]  alu_b;
   skrt_pkg::alu_out_type alu;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != skrt_pkg::S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign idx_inc    = idx_ff + CNT_W'(1);
   assign idx_dec    = idx_ff - CNT_W'(1);
   assign dump_last  = (idx_inc == count_ff);
   assign rd_addr    = rd_idx[ADDR_W-1:0];
   assign wr_addr    = wr_idx[ADDR_W-1:0];

   skrt_store #(
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_addr (wr_addr),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_qty  (rd_qty)
   );

   skrt_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .result (alu)
   );

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skrt_pkg::S_IDLE: begin
            if (req_accept) begin
               priority if (req_opcode == skrt_pkg::OP_INSERT &&
                            count_ff == CNT_W'(MAX_ENTRIES)) begin
                  state_in = skrt_pkg::S_RESPOND;
               end else if (req_opcode == skrt_pkg::OP_DUMP) begin
                  state_in = (count_ff == '0) ? skrt_pkg::S_RESPOND : skrt_pkg::S_DUMP_RD;
               end else if (req_opcode == skrt_pkg::OP_INSERT ||
                            req_opcode == skrt_pkg::OP_LOOKUP ||
                            req_opcode == skrt_pkg::OP_UPDATE ||
                            req_opcode == skrt_pkg::OP_ERASE) begin
                  state_in = skrt_pkg::S_SCAN_RD;
               end else begin
                  state_in = skrt_pkg::S_IDLE;
               end
            end
         end
         skrt_pkg::S_SCAN_RD: begin
            state_in = (idx_ff == count_ff) ? skrt_pkg::S_DECIDE : skrt_pkg::S_SCAN_CMP;
         end
         skrt_pkg::S_SCAN_CMP: begin
            state_in = alu.lt ? skrt_pkg::S_SCAN_RD : skrt_pkg::S_DECIDE;
         end
         skrt_pkg::S_DECIDE: begin
            unique case (op_ff)
               skrt_pkg::OP_INSERT: begin
                  state_in = found_ff ? skrt_pkg::S_RESPOND : skrt_pkg::S_INS_RD;
               end
               skrt_pkg::OP_ERASE: begin
                  state_in = found_ff ? skrt_pkg::S_DEL_RD : skrt_pkg::S_RESPOND;
               end
               default: begin
                  state_in = skrt_pkg::S_RESPOND;
               end
            endcase
         end
         skrt_pkg::S_INS_RD: begin
            state_in = (idx_ff == pos_ff) ? skrt_pkg::S_RESPOND : skrt_pkg::S_INS_WR;
         end
         skrt_pkg::S_INS_WR: begin
            state_in = skrt_pkg::S_INS_RD;
         end
         skrt_pkg::S_DEL_RD: begin
            state_in = (idx_inc >= count_ff) ? skrt_pkg::S_RESPOND : skrt_pkg::S_DEL_WR;
         end
         skrt_pkg::S_DEL_WR: begin
            state_in = skrt_pkg::S_DEL_RD;
         end
         skrt_pkg::S_DUMP_RD: begin
            state_in = skrt_pkg::S_DUMP_EMIT;
         end
         skrt_pkg::S_DUMP_EMIT: begin
            if (out_free) begin
               state_in = dump_last ? skrt_pkg::S_IDLE : skrt_pkg::S_DUMP_RD;
            end
         end
         skrt_pkg::S_RESPOND: begin
            if (out_free) begin
               state_in = skrt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = skrt_pkg::S_IDLE;
         end
      endcase
   end

   // Memory, shared unit and response control.
   always_comb begin
      rd_idx        = idx_ff;
      wr_idx        = idx_ff;
      wr.en         = 1'b0;
      wr.key        = rd_key;
      wr.qty        = rd_qty;
      alu_a         = rd_key;
      alu_b         = key_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         skrt_pkg::S_DECIDE: begin
            // The adder serves the quantity update; compares are done by now.
            if (op_ff == skrt_pkg::OP_UPDATE && found_ff) begin
               alu_a  = rd_qty;
               alu_b  = amt_ff;
               wr.en  = 1'b1;
               wr.key = key_ff;
               wr.qty = alu.sum;
            end
         end
         skrt_pkg::S_INS_RD: begin
            rd_idx = idx_dec;
            if (idx_ff == pos_ff) begin
               wr.en  = 1'b1;
               wr.key = key_ff;
               wr.qty = amt_ff;
            end
         end
         skrt_pkg::S_INS_WR: begin
            wr.en = 1'b1;
         end
         skrt_pkg::S_DEL_RD: begin
            rd_idx = idx_inc;
         end
         skrt_pkg::S_DEL_WR: begin
            wr.en = 1'b1;
         end
         skrt_pkg::S_DUMP_EMIT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = skrt_pkg::STAT_OK;
               rsp_key_in    = rd_key;
               rsp_qty_in    = rd_qty;
               rsp_last_in   = dump_last;
            end
         end
         skrt_pkg::S_RESPOND: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = status_ff;
               rsp_key_in    = (op_ff == skrt_pkg::OP_DUMP) ? 32'sd0 : key_ff;
               rsp_qty_in    = qty_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // Working registers of the item under work.
   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      amt_in    = amt_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      found_in  = found_ff;
      status_in = status_ff;
      qty_in    = qty_ff;
      unique case (state_ff)
         skrt_pkg::S_IDLE: begin
            if (req_accept) begin
               op_in     = req_opcode;
               key_in    = req_part_key;
               amt_in    = req_amount;
               idx_in    = '0;
               qty_in    = 32'sd0;
               found_in  = 1'b0;
               status_in = (req_opcode == skrt_pkg::OP_DUMP) ? skrt_pkg::STAT_EMPTY
                                                            : skrt_pkg::STAT_FULL;
            end
         end
         skrt_pkg::S_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               found_in = 1'b0;
            end
         end
         skrt_pkg::S_SCAN_CMP: begin
            if (alu.lt) begin
               idx_in = idx_inc;
            end else begin
               found_in = alu.eq;
            end
         end
         skrt_pkg::S_DECIDE: begin
            status_in = found_ff ? skrt_pkg::STAT_OK : skrt_pkg::STAT_NOT_FOUND;
            unique case (op_ff)
               skrt_pkg::OP_INSERT: begin
                  status_in = skrt_pkg::STAT_DUPLICATE;
                  pos_in    = idx_ff;
                  idx_in    = count_ff;
               end
               skrt_pkg::OP_LOOKUP: begin
                  if (found_ff) begin
                     qty_in = rd_qty;
                  end
               end
               skrt_pkg::OP_UPDATE: begin
                  if (found_ff) begin
                     qty_in = alu.sum;
                  end
               end
               default: begin
               end
            endcase
         end
         skrt_pkg::S_INS_RD: begin
            if (idx_ff == pos_ff) begin
               count_in  = count_ff + CNT_W'(1);
               status_in = skrt_pkg::STAT_OK;
            end
         end
         skrt_pkg::S_INS_WR: begin
            idx_in = idx_dec;
         end
         skrt_pkg::S_DEL_RD: begin
            if (idx_inc >= count_ff) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         skrt_pkg::S_DEL_WR: begin
            idx_in = idx_inc;
         end
         skrt_pkg::S_DUMP_EMIT: begin
            if (out_free && !dump_last) begin
               idx_in = idx_inc;
            end
         end
         default: begin
         end
      endcase
   end

   // Shift moves write to the current index, reading one slot away.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skrt_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      amt_ff        <= amt_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      qty_ff        <= qty_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_out_quantity = rsp_qty_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

@@ tb/tb_sorted_keyed_record_table_core.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_keyed_record_table_core
// Self-checking bench for the sorted record table. A short table of directed
// requests covers the key and quantity extremes, every operation, all status
// codes but full and two unused opcodes. A few hundred random requests follow,
// shaped to fill the table, churn it and drain it again. Every accepted
// request is run through a local model of the table, and every response item
// is compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_sorted_keyed_record_table_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_DEPTH  = 32;
   localparam int unsigned RANDOM_ITEMS = 335;
   localparam int unsigned POOL_SIZE    = 36;
   localparam int unsigned DRAIN_CYCLES = 4 * TABLE_DEPTH + 20;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned REPORT_LIMIT = 10;

   // Opcodes the block must swallow without a response.
   localparam logic [2:0] OP_RSVD5 = 3'd5;
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;

   // One response item as the block should present it.
   typedef struct packed {
      skrt_pkg::status_type status;
      logic signed [31:0]   key;
      logic signed [31:0]   qty;
      logic                 last;
   } outcome_type;

   // Travels with each offered request: when fixed is set, the typed-in
   // outcome replaces whatever the local model would predict.
   typedef struct packed {
      bit          fixed;
      outcome_type want;
   } pinned_type;

   typedef struct packed {
      logic [2:0]           op;
      logic signed [31:0]   key;
      logic signed [31:0]   amt;
      bit                   fixed;
      skrt_pkg::status_type st;
      logic signed [31:0]   ekey;
      logic signed [31:0]   eqty;
   } directed_row_type;

   // Directed requests. The table starts empty, is loaded with the four
   // key extremes plus one, probed, wrapped and then emptied again.
   directed_row_type directed_rows [0:24] = '{
      '{skrt_pkg::OP_DUMP,   32'sh0,        32'sh0,        1'b1,
        skrt_pkg::STAT_EMPTY,     32'sh0,        32'sh0},
      '{skrt_pkg::OP_LOOKUP, 32'sh0,        32'sh0,        1'b1,
        skrt_pkg::STAT_NOT_FOUND, 32'sh0,        32'sh0},
      '{skrt_pkg::OP_UPDATE, 32'sh7fffffff, 32'sh5,        1'b1,
        skrt_pkg::STAT_NOT_FOUND, 32'sh7fffffff, 32'sh0},
      '{skrt_pkg::OP_ERASE,  32'sh80000000, 32'sh0,        1'b1,
        skrt_pkg::STAT_NOT_FOUND, 32'sh80000000, 32'sh0},
      '{skrt_pkg::OP_INSERT, 32'sh7fffffff, 32'sh7fffffff, 1'b1,
        skrt_pkg::STAT_OK,        32'sh7fffffff, 32'sh0},
      '{skrt_pkg::OP_INSERT, 32'sh80000000, 32'sh80000000, 1'b1,
        skrt_pkg::STAT_OK,        32'sh80000000, 32'sh0},
      '{skrt_pkg::OP_INSERT, 32'sh0,        32'shffffffff, 1'b1,
        skrt_pkg::STAT_OK,        32'sh0,        32'sh0},
      '{skrt_pkg::OP_INSERT, 32'shffffffff, 32'sh1,        1'b1,
        skrt_pkg::STAT_OK,        32'shffffffff, 32'sh0},
      '{skrt_pkg::OP_INSERT, 32'sh1,        32'sh0,        1'b1,
        skrt_pkg::STAT_OK,        32'sh1,        32'sh0},
      '{skrt_pkg::OP_INSERT, 32'sh0,        32'sh5,        1'b1,
        skrt_pkg::STAT_DUPLICATE, 32'sh0,        32'sh0},
      '{skrt_pkg::OP_DUMP,   32'sh0,        32'sh0,        1'b0,
        skrt_pkg::STAT_OK,        32'sh0,        32'sh0},
      '{skrt_pkg::OP_LOOKUP, 32'sh7fffffff, 32'sh0,        1'b1,
        skrt_pkg::STAT_OK,        32'sh7fffffff, 32'sh7fffffff},
      '{skrt_pkg::OP_UPDATE, 32'sh7fffffff, 32'sh1,        1'b0,
        skrt_pkg::STAT_OK,        32'sh0,        32'sh0},
      '{skrt_pkg::OP_UPDATE, 32'sh80000000, 32'shffffffff, 1'b0,
        skrt_pkg::STAT_OK,        32'sh0,        32'sh0},
      '{skrt_pkg::OP_LOOKUP, 32'sh80000000, 32'sh0,        1'b0,
        skrt_pkg::STAT_OK,        32'sh0,        32'sh0},
      '{OP_RSVD5,            32'sh55555555, 32'shaaaaaaaa, 1'b0,
        skrt_pkg::STAT_OK,        32'sh0,        32'sh0},
      '{OP_RSVD7,            32'shffffffff, 32'shffffffff, 1'b0,
        skrt_pkg::STAT_OK,        32'sh0,        32'sh0},
      '{skrt_pkg::OP_ERASE,  32'sh0,        32'sh0,        1'b1,
        skrt_pkg::STAT_OK,        32'sh0,        32'sh0},
      '{skrt_pkg::OP_ERASE,  32'sh80000000, 32'sh0,        1'b1,
        skrt_pkg::STAT_OK,        32'sh80000000, 32'sh0},
      '{skrt_pkg::OP_ERASE,  32'sh7fffffff, 32'sh0,        1'b1,
        skrt_pkg::STAT_OK,        32'sh7fffffff, 32'sh0},
      '{skrt_pkg::OP_LOOKUP, 32'sh0,        32'sh0,        1'b1,
        skrt_pkg::STAT_NOT_FOUND, 32'sh0,        32'sh0},
      '{skrt_pkg::OP_DUMP,   32'sh0,        32'sh0,        1'b0,
        skrt_pkg::STAT_OK,        32'sh0,        32'sh0},
      '{skrt_pkg::OP_ERASE,  32'shffffffff, 32'sh0,        1'b0,
        skrt_pkg::STAT_OK,        32'sh0,        32'sh0},
      '{skrt_pkg::OP_ERASE,  32'sh1,        32'sh0,        1'b0,
        skrt_pkg::STAT_OK,        32'sh0,        32'sh0},
      '{skrt_pkg::OP_DUMP,   32'sh0,        32'sh0,        1'b1,
        skrt_pkg::STAT_EMPTY,     32'sh0,        32'sh0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_opcode = skrt_pkg::OP_INSERT;
   logic signed [31:0] req_part_key = '0;
   logic signed [31:0] req_amount = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_out_key;
   logic signed [31:0] rsp_out_quantity;
   logic               rsp_last;

   // Local copy of the table: sorted keys and their quantities.
   logic signed [31:0] table_keys [TABLE_DEPTH];
   logic signed [31:0] table_qtys [TABLE_DEPTH];
   int unsigned        table_count = 0;

   outcome_type        pending_results [$];
   pinned_type         pinned_q [$];
   logic signed [31:0] key_pool [POOL_SIZE];
   int unsigned        result_errors = 0;
   bit                 gaps_on = 1'b1;

   sorted_keyed_record_table_core #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_part_key     (req_part_key),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_quantity (rsp_out_quantity),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs or stops answering.
   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic void queue_result(skrt_pkg::status_type st, logic signed [31:0] k,
                                        logic signed [31:0] q, logic last);
      outcome_type o;
      o.status = st;
      o.key    = k;
      o.qty    = q;
      o.last   = last;
      pending_results.push_back(o);
   endfunction

   // Applies one accepted request to the local table and queues the response
   // items it should produce. Keys are compared as signed numbers.
   function automatic void apply_to_table(logic [2:0] op, logic signed [31:0] k,
                                          logic signed [31:0] a);
      int unsigned pos;
      bit          hit;
      pos = 0;
      while (pos < table_count && k > table_keys[pos])
         pos++;
      hit = (pos < table_count) && (table_keys[pos] == k);
      case (op)
         skrt_pkg::OP_INSERT: begin
            // A full table wins over a duplicate key.
            if (table_count >= TABLE_DEPTH) begin
               queue_result(skrt_pkg::STAT_FULL, k, '0, 1'b1);
            end else if (hit) begin
               queue_result(skrt_pkg::STAT_DUPLICATE, k, '0, 1'b1);
            end else begin
               for (int i = table_count; i > pos; i--) begin
                  table_keys[i] = table_keys[i-1];
                  table_qtys[i] = table_qtys[i-1];
               end
               table_keys[pos] = k;
               table_qtys[pos] = a;
               table_count++;
               queue_result(skrt_pkg::STAT_OK, k, '0, 1'b1);
            end
         end
         skrt_pkg::OP_LOOKUP: begin
            if (hit)
               queue_result(skrt_pkg::STAT_OK, k, table_qtys[pos], 1'b1);
            else
               queue_result(skrt_pkg::STAT_NOT_FOUND, k, '0, 1'b1);
         end
         skrt_pkg::OP_UPDATE: begin
            if (hit) begin
               table_qtys[pos] = table_qtys[pos] + a;
               queue_result(skrt_pkg::STAT_OK, k, table_qtys[pos], 1'b1);
            end else begin
               queue_result(skrt_pkg::STAT_NOT_FOUND, k, '0, 1'b1);
            end
         end
         skrt_pkg::OP_ERASE: begin
            if (hit) begin
               for (int i = pos; i + 1 < table_count; i++) begin
                  table_keys[i] = table_keys[i+1];
                  table_qtys[i] = table_qtys[i+1];
               end
               table_count--;
               queue_result(skrt_pkg::STAT_OK, k, '0, 1'b1);
            end else begin
               queue_result(skrt_pkg::STAT_NOT_FOUND, k, '0, 1'b1);
            end
         end
         skrt_pkg::OP_DUMP: begin
            if (table_count == 0) begin
               queue_result(skrt_pkg::STAT_EMPTY, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < table_count; i++)
                  queue_result(skrt_pkg::STAT_OK, table_keys[i], table_qtys[i],
                               (i + 1 == table_count));
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Picks a key: from the stored records (table_pct percent, when there
   // are any), fresh from the whole 32-bit range (fresh_pct percent), or
   // otherwise from the shared pool so that keys repeat and collide.
   function automatic logic signed [31:0] pick_key(int unsigned table_pct,
                                                   int unsigned fresh_pct);
      if (table_count > 0 && $urandom_range(99) < table_pct)
         return table_keys[$urandom_range(table_count - 1)];
      if ($urandom_range(99) < fresh_pct)
         return $urandom;
      return key_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   // Offers one request item, with random idle cycles ahead of it while gaps
   // are enabled, and returns at the edge where the block accepts it. Valid
   // is only lowered by an idle cycle, so back-to-back items keep it high.
   task automatic offer(input logic [2:0] op, input logic signed [31:0] k,
                        input logic signed [31:0] a, input pinned_type pin);
      while (gaps_on && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_part_key <= k;
      req_amount   <= a;
      pinned_q.push_back(pin);
      do @(posedge clock); while (req_stall);
   endtask

   // Scoreboard. Both handshakes are sampled at the rising edge, so the
   // values seen are the ones the block saw. A request accepted at an edge is
   // predicted before any response at that same edge is checked.
   always @(posedge clock) begin : scoreboard
      pinned_type  pin;
      outcome_type want;
      int unsigned prior_n;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pin = pinned_q.pop_front();
            prior_n = pending_results.size();
            apply_to_table(req_opcode, req_part_key, req_amount);
            if (pin.fixed) begin
               while (pending_results.size() > prior_n)
                  void'(pending_results.pop_back());
               pending_results.push_back(pin.want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               result_errors++;
               if (result_errors <= REPORT_LIMIT)
                  $display("%0t: unexpected response item:", $realtime,
                           " status %0d key %0d qty %0d last %0b",
                           rsp_status, rsp_out_key, rsp_out_quantity, rsp_last);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status || rsp_out_key !== want.key ||
                   rsp_out_quantity !== want.qty || rsp_last !== want.last) begin
                  result_errors++;
                  if (result_errors <= REPORT_LIMIT)
                     $display("%0t: response mismatch: expected status %0d key %0d",
                              $realtime, want.status, want.key,
                              " qty %0d last %0b,", want.qty, want.last,
                              " got status %0d key %0d qty %0d last %0b",
                              rsp_status, rsp_out_key, rsp_out_quantity, rsp_last);
               end
            end
         end
      end
   end

   // Receiver. It stalls at random about a quarter of the time, stays
   // stall-free over a stretch of responses, and twice holds off for a long
   // run of cycles so the block backs up and stalls its request side while
   // the sender keeps an item on offer.
   initial begin : receiver
      int unsigned taken;
      int unsigned hold_left;
      bit          first_hold_done;
      bit          second_hold_done;
      taken = 0;
      hold_left = 0;
      first_hold_done = 1'b0;
      second_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            taken++;
         if (!first_hold_done && taken >= 150) begin
            first_hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (!second_hold_done && taken >= 500) begin
            second_hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (taken >= 60 && taken < 140) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 26);
         end
      end
   end

   // Stimulus: reset, the directed table, then the random requests in three
   // phases. The first leans on inserts to fill the table, the second mixes
   // every operation, the third leans on erases to drain it again.
   initial begin : stimulus
      pinned_type         pin;
      pinned_type         free_pin;
      logic [2:0]         op;
      logic signed [31:0] k;
      logic signed [31:0] a;
      int unsigned        issued;
      int unsigned        roll;
      int unsigned        w_ins, w_look, w_upd, w_era;

      free_pin = '0;

      // The first entries double as corner values for keys and amounts.
      key_pool[0] = 32'sh80000000;
      key_pool[1] = 32'sh7fffffff;
      key_pool[2] = 32'sh0;
      key_pool[3] = 32'shffffffff;
      key_pool[4] = 32'sh1;
      key_pool[5] = 32'sh80000001;
      for (int i = 6; i < POOL_SIZE; i++) begin
         if (i % 2 == 0)
            key_pool[i] = $signed($urandom_range(2000)) - 1000;
         else
            key_pool[i] = $urandom;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         pin.fixed       = directed_rows[r].fixed;
         pin.want.status = directed_rows[r].st;
         pin.want.key    = directed_rows[r].ekey;
         pin.want.qty    = directed_rows[r].eqty;
         pin.want.last   = 1'b1;
         offer(directed_rows[r].op, directed_rows[r].key, directed_rows[r].amt, pin);
      end

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         // A stretch of back-to-back requests with no idle cycles.
         gaps_on = !(issued >= 150 && issued < 220);

         if (issued < 140) begin
            w_ins = 60; w_look = 15; w_upd = 12; w_era = 5;
         end else if (issued < 250) begin
            w_ins = 25; w_look = 20; w_upd = 20; w_era = 25;
         end else begin
            w_ins = 10; w_look = 15; w_upd = 10; w_era = 57;
         end

         if ($urandom_range(99) < 3) begin
            // Unused opcodes are ignored by the block and not counted.
            case ($urandom_range(2))
               0:       op = OP_RSVD5;
               1:       op = OP_RSVD6;
               default: op = OP_RSVD7;
            endcase
            offer(op, $urandom, $urandom, free_pin);
         end else begin
            roll = $urandom_range(99);
            if ($urandom_range(9) == 0)
               a = key_pool[$urandom_range(5)];
            else
               a = $urandom;
            if (roll < w_ins) begin
               op = skrt_pkg::OP_INSERT;
               k  = pick_key(0, 30);
            end else if (roll < w_ins + w_look) begin
               op = skrt_pkg::OP_LOOKUP;
               k  = pick_key(50, 10);
            end else if (roll < w_ins + w_look + w_upd) begin
               op = skrt_pkg::OP_UPDATE;
               k  = pick_key(50, 10);
            end else if (roll < w_ins + w_look + w_upd + w_era) begin
               op = skrt_pkg::OP_ERASE;
               k  = pick_key(60, 10);
            end else begin
               op = skrt_pkg::OP_DUMP;
               k  = $urandom;
            end
            offer(op, k, a, free_pin);
            issued++;
         end
      end
      req_valid <= 1'b0;

      // Wait for the outstanding responses, then give the block time to
      // show any stray item before judging.
      @(negedge clock);
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (result_errors == 0 && pending_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
